@@ rtl/pgpc_pkg.sv @@
// ----------------------------------------------------------------------------
// pgpc_pkg: shared types and constants of the pixel gain/pedestal corrector
// Word layouts of both stream channels, the register bundle, and the raster
// position that travels from the counter module to the datapath.
// ----------------------------------------------------------------------------
package pgpc_pkg;

  // Raw sample layout: two gain bits above a 14-bit ADC value.
  localparam int unsigned GROUP_SHIFT = 14;
  localparam logic [13:0] ADC_MASK    = 14'h3FFF;

  // Fixed field widths.
  localparam int unsigned ROW_W   = 9;
  localparam int unsigned COL_W   = 10;
  localparam int unsigned PIX_W   = 19;
  localparam int unsigned ADDR_W  = 26;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned PED_W   = 18;
  localparam int unsigned ENTRY_W = GAIN_W + PED_W;

  // Item kinds carried in the mode field.
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [1:0]                gain_select;
    logic [PIX_W-1:0]          pixel_index;
    logic signed [GAIN_W-1:0]  gain_value;
    logic [PED_W-1:0]          pedestal_value;
    logic [15:0]               raw_sample;
  } in_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  out_address;
    logic signed [31:0] out_value;
    logic               last_of_module;
  } out_word_t;

  typedef struct packed {
    logic              apply_calibration;
    logic [15:0]       row_stride;
    logic [ADDR_W-1:0] start_offset;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             last;
  } pos_t;

endpackage

@@ rtl/pgpc_apb_regs.sv @@
// ----------------------------------------------------------------------------
// pgpc_apb_regs: configuration registers behind an APB-style port
// Three registers at byte addresses 0, 4 and 8; pready is always high.
// ----------------------------------------------------------------------------
module pgpc_apb_regs
  import pgpc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  typedef enum logic [1:0] {
    REG_APPLY  = 2'd0,
    REG_STRIDE = 2'd1,
    REG_OFFSET = 2'd2
  } reg_idx_e;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.apply_calibration <= 1'b0;
      cfg_q.row_stride        <= 16'd1024;
      cfg_q.start_offset      <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_APPLY:  cfg_q.apply_calibration <= pwdata[0];
        REG_STRIDE: cfg_q.row_stride        <= pwdata[15:0];
        REG_OFFSET: cfg_q.start_offset      <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_APPLY:  prdata = {31'd0, cfg_q.apply_calibration};
      REG_STRIDE: prdata = {16'd0, cfg_q.row_stride};
      REG_OFFSET: prdata = {{(32 - ADDR_W){1'b0}}, cfg_q.start_offset};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/pgpc_raster.sv @@
// ----------------------------------------------------------------------------
// pgpc_raster: raster position of the next pixel
// Column and row counters that wrap at the module size, plus the flag for
// the module's final pixel.
// ----------------------------------------------------------------------------
module pgpc_raster
  import pgpc_pkg::*;
#(
  parameter int unsigned MODULE_COLUMNS = 1024,
  parameter int unsigned MODULE_ROWS    = 512
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  output pos_t pos_o
);

  localparam logic [COL_W-1:0] ColLast = COL_W'(MODULE_COLUMNS - 1);
  localparam logic [ROW_W-1:0] RowLast = ROW_W'(MODULE_ROWS - 1);

  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (advance_i) begin
      if (col_q == ColLast) begin
        col_d = '0;
        row_d = (row_q == RowLast) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  assign pos_o.row  = row_q;
  assign pos_o.col  = col_q;
  assign pos_o.last = (row_q == RowLast) && (col_q == ColLast);

endmodule

@@ rtl/pgpc_cal_mem.sv @@
// ----------------------------------------------------------------------------
// pgpc_cal_mem: calibration table storage
// Single-port synchronous memory; one write or one registered read a cycle.
// ----------------------------------------------------------------------------
module pgpc_cal_mem #(
  parameter int unsigned DEPTH = 1572864,
  parameter int unsigned AW    = 21,
  parameter int unsigned DW    = 42
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [DW-1:0] wdata_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/pixel_gain_pedestal_corrector_unit.sv @@
// ----------------------------------------------------------------------------
// pixel_gain_pedestal_corrector_unit: per-pixel pedestal and gain correction
// Pipeline: a pixel word is registered into stage 1, stage 2 and stage 3 in
// order; out_valid_o rises once it sits in the stage 3 output register.
// Throughput: one word per cycle while in_stall_o is low, loads and pixels
// alike, set by the single calibration memory port that each word uses once.
// Reset: counters and valid flags clear, configuration registers take their
// reset values (row stride 1024); the table stays unknown.
// ----------------------------------------------------------------------------
module pixel_gain_pedestal_corrector_unit
  import pgpc_pkg::*;
#(
  parameter int unsigned MODULE_COLUMNS = 1024,
  parameter int unsigned MODULE_ROWS    = 512,
  parameter int unsigned NUM_GAINS      = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  // Output stream.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // The table holds NUM_GAINS banks of one entry per module pixel, laid out
  // bank after bank in one flat address space.
  localparam int unsigned PixPerModule = MODULE_ROWS * MODULE_COLUMNS;
  localparam int unsigned MemDepth     = NUM_GAINS * PixPerModule;
  localparam int unsigned MemAw        = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  cfg_t cfg;
  pos_t pos;

  pgpc_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline flow control. Each stage takes a new word when it is empty or
  // when the stage after it moves, so bubbles close up and the input keeps
  // flowing into empty stages while a stalled word waits at the output.
  logic s1_v_q, s2_v_q, s3_v_q;
  logic s1_rdy, s2_rdy, s3_rdy;

  assign s3_rdy     = !s3_v_q || !out_stall_i;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_stall_o = !s1_rdy;

  logic accept, pix_acc, load_acc;

  assign accept   = in_valid_i && s1_rdy;
  assign pix_acc  = accept && (in_word_i.mode == MODE_PIXEL);
  // Loads to a gain group or pixel index outside the module are dropped.
  assign load_acc = accept && (in_word_i.mode == MODE_LOAD)
                 && ({1'b0, in_word_i.gain_select} < 3'(NUM_GAINS))
                 && ({1'b0, in_word_i.pixel_index} < (PIX_W + 1)'(PixPerModule));

  pgpc_raster #(
    .MODULE_COLUMNS (MODULE_COLUMNS),
    .MODULE_ROWS    (MODULE_ROWS)
  ) u_raster (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (pix_acc),
    .pos_o     (pos)
  );

  // The gain group of a pixel is the top two sample bits reduced modulo
  // NUM_GAINS; with at most four groups three conditional subtractions do.
  logic [2:0] pix_group;
  always_comb begin
    pix_group = {1'b0, in_word_i.raw_sample[15:GROUP_SHIFT]};
    for (int k = 0; k < 3; k++) begin
      if (pix_group >= 3'(NUM_GAINS)) begin
        pix_group = pix_group - 3'(NUM_GAINS);
      end
    end
  end

  logic [MemAw-1:0]   pix_addr, load_addr, mem_addr;
  logic [PIX_W-1:0]   pix_index;
  logic [ENTRY_W-1:0] mem_rdata;

  assign pix_index = PIX_W'(pos.row) * PIX_W'(MODULE_COLUMNS) + PIX_W'(pos.col);
  assign pix_addr  = MemAw'(pix_group) * MemAw'(PixPerModule) + MemAw'(pix_index);
  assign load_addr = MemAw'(in_word_i.gain_select) * MemAw'(PixPerModule)
                   + MemAw'(in_word_i.pixel_index);
  assign mem_addr  = load_acc ? load_addr : pix_addr;

  // A load writes at its own accept edge and any later pixel reads at a later
  // edge, so a read always sees every earlier load without forwarding.
  pgpc_cal_mem #(
    .DEPTH (MemDepth),
    .AW    (MemAw),
    .DW    (ENTRY_W)
  ) u_mem (
    .clk_i   (clk_i),
    .en_i    (pix_acc || load_acc),
    .we_i    (load_acc),
    .addr_i  (mem_addr),
    .wdata_i ({in_word_i.gain_value, in_word_i.pedestal_value}),
    .rdata_o (mem_rdata)
  );

  // Stage 1: the calibration entry arrives from memory next to the sample.
  logic [15:0] s1_sample_q;
  pos_t        s1_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= pix_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_sample_q <= in_word_i.raw_sample;
      s1_pos_q    <= pos;
    end
  end

  // Difference of the Q14.4 ADC value and pedestal, then the product with
  // the Q8.16 gain, a Q.20 number of 43 bits.
  logic [PED_W-1:0]         s1_ped;
  logic signed [GAIN_W-1:0] s1_gain;
  logic signed [18:0]       s1_diff;
  logic signed [42:0]       s1_prod;
  logic [24:0]              s1_row_off;
  logic [ADDR_W-1:0]        s1_addr;

  assign s1_ped     = mem_rdata[PED_W-1:0];
  assign s1_gain    = $signed(mem_rdata[ENTRY_W-1:PED_W]);
  assign s1_diff    = $signed({1'b0, s1_sample_q[GROUP_SHIFT-1:0] & ADC_MASK, 4'b0000})
                    - $signed({1'b0, s1_ped});
  assign s1_prod    = s1_diff * s1_gain;
  // Output address wraps modulo the 26-bit image index range.
  assign s1_row_off = 25'(s1_pos_q.row) * 25'(cfg.row_stride);
  assign s1_addr    = cfg.start_offset + ADDR_W'(s1_row_off) + ADDR_W'(s1_pos_q.col);

  // Stage 2: product and address registered.
  logic signed [42:0] s2_prod_q;
  logic [ADDR_W-1:0]  s2_addr_q;
  logic [15:0]        s2_sample_q;
  logic               s2_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_prod_q   <= s1_prod;
      s2_addr_q   <= s1_addr;
      s2_sample_q <= s1_sample_q;
      s2_last_q   <= s1_pos_q.last;
    end
  end

  // Round to nearest with ties upward and drop 12 fraction bits. The 43-bit
  // product shifted by 12 always fits 32 bits, so the saturation bounds are
  // never reached and the upper slice is the saturated result.
  logic signed [43:0] s2_rnd;
  logic signed [31:0] s2_value;

  assign s2_rnd   = 44'(s2_prod_q) + 44'sd2048;
  assign s2_value = cfg.apply_calibration ? $signed(s2_rnd[43:12])
                                          : $signed({16'd0, s2_sample_q});

  // Stage 3: output register.
  out_word_t s3_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_rdy) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && s2_v_q) begin
      s3_word_q.out_address    <= s2_addr_q;
      s3_word_q.out_value      <= s2_value;
      s3_word_q.last_of_module <= s2_last_q;
    end
  end

  assign out_valid_o = s3_v_q;
  assign out_word_o  = s3_word_q;

endmodule

@@ rtl/pgpc_checker.sv @@
// ----------------------------------------------------------------------------
// pgpc_checker: port-level assertions for the corrector
// Watches the top level's ports and is attached to it by a bind statement.
// ----------------------------------------------------------------------------
module pgpc_checker
  import pgpc_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input out_word_t   out_word_o,
  input logic        psel,
  input logic        penable,
  input logic        pready
);

  // A held result word stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  // A held result word keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("output word changed while stalled");

  // With the output register empty the whole pipeline has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with an empty pipeline");

  // No result can appear in the cycle after reset releases.
  assert property (@(posedge clk_i)
    !$past(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // The configuration port never inserts wait states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable |-> pready)
    else $error("configuration access not ready");

endmodule

bind pixel_gain_pedestal_corrector_unit pgpc_checker u_pgpc_checker (.*);
